// ----- rtl/analog_hall_angle_tracker_unit_assert.svh -----
// Assertion macros used by the angle tracker checker
`ifndef ANALOG_HALL_ANGLE_TRACKER_UNIT_ASSERT_SVH
`define ANALOG_HALL_ANGLE_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define AHAT_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ahat check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define AHAT_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ahat check failed");

`endif

// ----- rtl/ahat_pkg.sv -----
// Types, constants and the arctangent table of the Hall angle tracker
`timescale 1ns / 1ps

package ahat_pkg;

  localparam int HALL_W  = 12;
  localparam int ANGLE_W = 16;
  localparam int TOTAL_W = 32;
  localparam int PP_W    = 5;

  // APB: one register, the 5-bit pole_pairs on the 32-bit bus, at byte address 0
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam int REG_W  = ADDR_W - 2;
  localparam logic [REG_W-1:0] REG_POLE_PAIRS = 1'd0;
  localparam logic [PP_W-1:0]  POLE_PAIRS_RST = 5'd1;

  // Clarke components: x is Q20, y = (b-c) * sqrt(3) in Q20
  localparam int FRAC  = 20;
  localparam int CW    = HALL_W + 24;
  localparam logic signed [22:0] SQRT3_Q20 = 23'sd1816187;

  // CORDIC angle, pi = 2^31
  localparam int ZW      = 34;
  localparam int ZMAG_W  = 32;
  localparam int Z_FRAC  = 31;
  localparam logic signed [ZW-1:0] Z_PI = 34'sh0_8000_0000;
  localparam int SCALE_W = 15;
  localparam logic [SCALE_W-1:0] ELEC_SCALE = 15'd32767;
  localparam int PROD_W  = ZMAG_W + SCALE_W;

  localparam logic [ANGLE_W-1:0] ELEC_PI   = 16'd32767;
  localparam logic [ANGLE_W-1:0] ELEC_HALF = 16'd16383;

  // magnitude of the electrical angle fits in 15 bits
  localparam int QW = ANGLE_W - 1;

  localparam int ATAN_LEN = 20;
  localparam int STEP_W   = 5;

  // datapath operations
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 4'd1;
  localparam logic [OP_W-1:0] OP_PREP   = 4'd2;
  localparam logic [OP_W-1:0] OP_SET    = 4'd3;
  localparam logic [OP_W-1:0] OP_ROT    = 4'd4;
  localparam logic [OP_W-1:0] OP_ITER   = 4'd5;
  localparam logic [OP_W-1:0] OP_SCALE  = 4'd6;
  localparam logic [OP_W-1:0] OP_NORM   = 4'd7;
  localparam logic [OP_W-1:0] OP_DIVI   = 4'd8;
  localparam logic [OP_W-1:0] OP_DIVS   = 4'd9;
  localparam logic [OP_W-1:0] OP_MECH   = 4'd10;
  localparam logic [OP_W-1:0] OP_COMMIT = 4'd11;

  typedef struct packed {
    logic                      cmd;
    logic [HALL_W-1:0]         hall_a;
    logic [HALL_W-1:0]         hall_b;
    logic [HALL_W-1:0]         hall_c;
    logic signed [ANGLE_W-1:0] new_mech_angle;
  } sample_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] elec_angle;
    logic signed [ANGLE_W-1:0] mech_angle;
    logic signed [ANGLE_W-1:0] mech_delta;
    logic signed [TOTAL_W-1:0] mech_angle_total;
  } angle_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [STEP_W-1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic is_set;
    logic axis;
  } dp_status_t;

  // atan(2^-i), pi = 2^31
  function automatic logic [31:0] atan_val(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2F9;
      5'd15:   v = 32'h0000517C;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A2F;
      5'd19:   v = 32'h00000517;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/ahat_ctrl.sv -----
// Sequencer of the Hall angle tracker: handshakes and datapath operations
`timescale 1ns / 1ps

module ahat_ctrl import ahat_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       sample_valid,
  output logic       sample_stall,
  output logic       angle_valid,
  input  logic       angle_stall,
  input  dp_status_t status,
  output dp_cmd_t    dp_cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_ROT   = 4'd2;
  localparam logic [3:0] S_ITER  = 4'd3;
  localparam logic [3:0] S_SCALE = 4'd4;
  localparam logic [3:0] S_NORM  = 4'd5;
  localparam logic [3:0] S_DIVI  = 4'd6;
  localparam logic [3:0] S_DIVS  = 4'd7;
  localparam logic [3:0] S_MECH  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  localparam logic [STEP_W-1:0] CORDIC_LAST = STEP_W'(CORDIC_STEPS - 1);
  localparam logic [STEP_W-1:0] DIV_LAST    = STEP_W'(QW - 1);

  logic [3:0]        state, state_next;
  logic [STEP_W-1:0] cnt, cnt_next;
  logic              commit;

  // nothing is taken while reset is held
  assign sample_stall = rst || (state != S_IDLE);

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    commit      = 1'b0;
    dp_cmd.op   = OP_NONE;
    dp_cmd.step = cnt;
    unique case (state)
      S_IDLE: begin
        if (sample_valid) begin
          dp_cmd.op  = OP_LOAD;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        if (status.is_set) begin
          dp_cmd.op  = OP_SET;
          state_next = S_FIN;
        end else begin
          dp_cmd.op  = OP_PREP;
          state_next = S_ROT;
        end
      end
      S_ROT: begin
        dp_cmd.op = OP_ROT;
        cnt_next  = '0;
        // vectors on an axis need no rotation
        state_next = status.axis ? S_DIVI : S_ITER;
      end
      S_ITER: begin
        dp_cmd.op = OP_ITER;
        if (cnt == CORDIC_LAST) begin
          state_next = S_SCALE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_SCALE: begin
        dp_cmd.op  = OP_SCALE;
        state_next = S_NORM;
      end
      S_NORM: begin
        dp_cmd.op  = OP_NORM;
        state_next = S_DIVI;
      end
      S_DIVI: begin
        dp_cmd.op  = OP_DIVI;
        cnt_next   = '0;
        state_next = S_DIVS;
      end
      S_DIVS: begin
        dp_cmd.op = OP_DIVS;
        if (cnt == DIV_LAST) begin
          state_next = S_MECH;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_MECH: begin
        dp_cmd.op  = OP_MECH;
        state_next = S_FIN;
      end
      S_FIN: begin
        // output register must be empty or emptying
        if (!angle_valid || !angle_stall) begin
          dp_cmd.op  = OP_COMMIT;
          commit     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      angle_valid <= 1'b0;
    end else begin
      state       <= state_next;
      cnt         <= cnt_next;
      angle_valid <= commit || (angle_valid && angle_stall);
    end
  end

endmodule

// ----- rtl/ahat_dp.sv -----
// Datapath: Clarke components, CORDIC vectoring, scaling, pole pair divider, totals
`timescale 1ns / 1ps

module ahat_dp import ahat_pkg::*; #(
  parameter int ADC_BITS = 12
) (
  input  logic            clk,
  input  logic            rst,
  input  dp_cmd_t         dp_cmd,
  output dp_status_t      status,
  input  sample_t         sample,
  input  logic [PP_W-1:0] pole_pairs,
  output angle_t          angle
);

  localparam int AW = (ADC_BITS < HALL_W) ? ADC_BITS : HALL_W;
  localparam logic [HALL_W-1:0] ADC_MASK = HALL_W'((64'd1 << AW) - 64'd1);

  logic                      cmd_bit;
  logic signed [HALL_W+1:0]  d_r;
  logic signed [HALL_W:0]    e_r;
  logic [ANGLE_W-1:0]        nma_r;
  logic signed [CW-1:0]      x_r, y_r;
  logic signed [ZW-1:0]      z_r;
  logic [PROD_W-1:0]         prod_r;
  logic                      zneg_r;
  logic [ANGLE_W-1:0]        elec_r, mech_r;
  logic [QW-1:0]             q_r;
  logic [PP_W-1:0]           rem_r;
  logic                      dneg_r;
  logic [ANGLE_W-1:0]        last_r;
  logic [TOTAL_W-1:0]        total_r;
  angle_t                    angle_r;

  logic [HALL_W-1:0]         ha, hb, hc;
  logic signed [HALL_W+1:0]  d_next;
  logic signed [HALL_W:0]    e_next;
  logic signed [CW-1:0]      y_mul, xs, ys;
  logic signed [ZW-1:0]      atan_z, zc;
  logic                      zneg;
  logic [ZMAG_W-1:0]         zmag;
  logic [PROD_W-1:0]         prod_next;
  logic [ANGLE_W-1:0]        mag16, elec_abs, set_elec, delta;
  logic [PP_W-1:0]           ppe;
  logic [PP_W:0]             rw, rw_sub;
  logic                      rw_ge;
  logic [TOTAL_W-1:0]        total_next;

  always_comb begin
    ha = sample.hall_a & ADC_MASK;
    hb = sample.hall_b & ADC_MASK;
    hc = sample.hall_c & ADC_MASK;
    d_next = $signed({1'b0, ha, 1'b0}) - $signed({2'b00, hb}) - $signed({2'b00, hc});
    e_next = $signed({1'b0, hb}) - $signed({1'b0, hc});

    y_mul  = CW'(e_r) * CW'(SQRT3_Q20);
    xs     = x_r >>> dp_cmd.step;
    ys     = y_r >>> dp_cmd.step;
    atan_z = ZW'(atan_val(dp_cmd.step));

    // clamp to [-pi, pi], then scale the magnitude by 32767 / 2^31
    if (z_r > Z_PI) begin
      zc = Z_PI;
    end else if (z_r < -Z_PI) begin
      zc = -Z_PI;
    end else begin
      zc = z_r;
    end
    zneg      = zc[ZW-1];
    zmag      = zneg ? ZMAG_W'(-zc) : ZMAG_W'(zc);
    prod_next = PROD_W'(zmag) * PROD_W'(ELEC_SCALE);
    mag16     = prod_r[Z_FRAC +: ANGLE_W];

    elec_abs = elec_r[ANGLE_W-1] ? -elec_r : elec_r;
    ppe      = (pole_pairs == '0) ? PP_W'(1) : pole_pairs;
    set_elec = nma_r * ANGLE_W'(ppe);

    // restoring divide, one quotient bit per step
    rw     = {rem_r, q_r[QW-1]};
    rw_ge  = (rw >= {1'b0, ppe});
    rw_sub = rw - {1'b0, ppe};

    delta      = cmd_bit ? '0 : (mech_r - last_r);
    total_next = cmd_bit ? total_r
                         : total_r + {{(TOTAL_W-ANGLE_W){delta[ANGLE_W-1]}}, delta};
  end

  assign status.is_set = cmd_bit;
  assign status.axis   = (x_r == '0) || (y_r == '0);
  assign angle         = angle_r;

  // tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_r  <= '0;
      total_r <= '0;
    end else if (dp_cmd.op == OP_COMMIT) begin
      last_r  <= mech_r;
      total_r <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (dp_cmd.op)
      OP_LOAD: begin
        cmd_bit <= sample.cmd;
        d_r     <= d_next;
        e_r     <= e_next;
        nma_r   <= sample.new_mech_angle;
      end
      OP_PREP: begin
        x_r <= CW'(d_r) <<< FRAC;
        y_r <= y_mul;
      end
      OP_SET: begin
        mech_r <= nma_r;
        elec_r <= set_elec;
      end
      OP_ROT: begin
        priority if (y_r == '0) begin
          elec_r <= (x_r < 0) ? ELEC_PI : '0;
        end else if (x_r == '0) begin
          elec_r <= (y_r > 0) ? ELEC_HALF : -ELEC_HALF;
        end else if (x_r < 0) begin
          // left half plane: rotate by pi first
          z_r <= (y_r >= 0) ? Z_PI : -Z_PI;
          x_r <= -x_r;
          y_r <= -y_r;
        end else begin
          z_r <= '0;
        end
      end
      OP_ITER: begin
        if (!y_r[CW-1]) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + atan_z;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - atan_z;
        end
      end
      OP_SCALE: begin
        prod_r <= prod_next;
        zneg_r <= zneg;
      end
      OP_NORM: begin
        elec_r <= zneg_r ? -mag16 : mag16;
      end
      OP_DIVI: begin
        q_r    <= elec_abs[QW-1:0];
        rem_r  <= '0;
        dneg_r <= elec_r[ANGLE_W-1];
      end
      OP_DIVS: begin
        if (rw_ge) begin
          rem_r <= rw_sub[PP_W-1:0];
          q_r   <= {q_r[QW-2:0], 1'b1};
        end else begin
          rem_r <= rw[PP_W-1:0];
          q_r   <= {q_r[QW-2:0], 1'b0};
        end
      end
      OP_MECH: begin
        mech_r <= dneg_r ? -ANGLE_W'(q_r) : ANGLE_W'(q_r);
      end
      OP_COMMIT: begin
        angle_r.elec_angle       <= elec_r;
        angle_r.mech_angle       <= mech_r;
        angle_r.mech_delta       <= delta;
        angle_r.mech_angle_total <= total_next;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/analog_hall_angle_tracker_unit.sv -----
// Channel  Dir  Handshake                   Payload
// sample   in   sample_valid / sample_stall sample_t: cmd, hall_a/b/c, new_mech_angle
// angle    out  angle_valid / angle_stall   angle_t: elec, mech, delta, total
// config   in   APB psel/penable/pwrite     pole_pairs at byte address 0x0
//
// Hall sample: after acceptance the sequencer runs PREP, ROT, CORDIC_STEPS CORDIC
// iterations, SCALE, NORM, DIVI, the 15-step pole pair divider, MECH and FIN.
// Vectors on an axis skip the CORDIC loop, SCALE and NORM. Set command: PREP, FIN.
// One transaction in flight; sample_stall is high from acceptance until the result
// is loaded into the output register, which holds it while angle_stall is high.
// Synchronous reset: pole_pairs = 1, angle_valid and total cleared, sample_stall held high.
`timescale 1ns / 1ps

module analog_hall_angle_tracker_unit import ahat_pkg::*; #(
  parameter int ADC_BITS     = 12,
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  sample_t           sample,
  output logic              angle_valid,
  input  logic              angle_stall,
  output angle_t            angle
);

  logic [PP_W-1:0] pole_pairs;
  logic            reg_sel;
  dp_cmd_t         dp_cmd;
  dp_status_t      status;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_W-1:2] == REG_POLE_PAIRS);
  assign prdata  = reg_sel ? DATA_W'(pole_pairs) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pole_pairs <= POLE_PAIRS_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      pole_pairs <= pwdata[PP_W-1:0];
    end
  end

  ahat_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .angle_valid  (angle_valid),
    .angle_stall  (angle_stall),
    .status       (status),
    .dp_cmd       (dp_cmd)
  );

  ahat_dp #(
    .ADC_BITS(ADC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .dp_cmd     (dp_cmd),
    .status     (status),
    .sample     (sample),
    .pole_pairs (pole_pairs),
    .angle      (angle)
  );

endmodule

// ----- rtl/ahat_checker.sv -----
// Port-level checks of the angle tracker, bound to the top level
`timescale 1ns / 1ps
`include "analog_hall_angle_tracker_unit_assert.svh"

module ahat_checker import ahat_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   sample_valid,
  input logic   sample_stall,
  input logic   angle_valid,
  input logic   angle_stall,
  input angle_t angle
);

  // a stalled result holds
  `AHAT_ASSERT_NXT(a_angle_hold, angle_valid && angle_stall, angle_valid && $stable(angle))

  // an accepted transaction keeps the block busy and yields no result at once
  `AHAT_ASSERT_NXT(a_busy_after_accept, sample_valid && !sample_stall, sample_stall && !$rose(angle_valid))

  // a new result comes from a busy block, which is then free again
  `AHAT_ASSERT_IMP(a_result_from_busy, $rose(angle_valid), $past(sample_stall))
  `AHAT_ASSERT_IMP(a_free_after_result, $rose(angle_valid), !sample_stall)

endmodule

bind analog_hall_angle_tracker_unit ahat_checker u_ahat_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .angle_valid  (angle_valid),
  .angle_stall  (angle_stall),
  .angle        (angle)
);
